[rtl/assert_macros.svh]
// assertion macros used by the top rtl file, aes_sbox_from_inverse_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/asbox_pkg.sv]
// types, constants, microcode rom and gf(2^8) helpers for the s-box unit
// no dependencies
package asbox_pkg;

    localparam logic [7:0] GF_POLY_LOW  = 8'h1B;
    localparam logic [7:0] AFFINE_CONST = 8'h63;
    localparam logic [7:0] ONE_BYTE     = 8'h01;
    localparam logic [2:0] LOOP_COUNT   = 3'd7;
    localparam logic [2:0] LOOP_LAST    = 3'd1;

    localparam logic [7:0] ROW_MASK [8] = '{
        8'hF8, 8'h7C, 8'h3E, 8'h1F, 8'h8F, 8'hC7, 8'hE3, 8'hF1
    };

    typedef enum logic [1:0] {
        OP_SQR,
        OP_MUL,
        OP_DONE
    } uop_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef logic [1:0] upc_t;

    typedef struct packed {
        uop_t uop;
        logic loop;
        upc_t target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic sqr;
        logic mul;
        logic out_load;
    } dp_ctrl_t;

    localparam upc_t UPC_START = 2'd0;
    localparam upc_t UPC_LOOP  = 2'd1;

    // x^254: square for the zero low bit, then seven multiply/square pairs
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{uop: OP_DONE, loop: 1'b0, target: UPC_START};
        case (addr)
            2'd0: w = '{uop: OP_SQR,  loop: 1'b0, target: UPC_START};
            2'd1: w = '{uop: OP_MUL,  loop: 1'b0, target: UPC_START};
            2'd2: w = '{uop: OP_SQR,  loop: 1'b1, target: UPC_LOOP};
            2'd3: w = '{uop: OP_DONE, loop: 1'b0, target: UPC_START};
            default: w = '{uop: OP_DONE, loop: 1'b0, target: UPC_START};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] affine(input logic [7:0] inv);
        logic [7:0] res;
        res = '0;
        for (int k = 0; k < 8; k++) begin
            res[7 - k] = (^(inv & ROW_MASK[k])) ^ AFFINE_CONST[7 - k];
        end
        return res;
    endfunction

endpackage

[rtl/asbox_useq.sv]
// microcode sequencer: step counter, loop counter, rom and beat handshake
// depends on asbox_pkg
module asbox_useq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output asbox_pkg::dp_ctrl_t ctrl
);
    import asbox_pkg::*;

    state_t     state_reg, state_next;
    upc_t       pc_reg, pc_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    ucode_t     uw;
    logic       accept;
    logic       out_free;

    assign uw       = ucode_rom(pc_reg);
    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (uw.uop == OP_DONE && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        ctrl         = '0;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.load = 1'b1;
                    pc_next   = UPC_START;
                    cnt_next  = LOOP_COUNT;
                end
            end
            ST_RUN: begin
                case (uw.uop)
                    OP_SQR: begin
                        ctrl.sqr = 1'b1;
                        if (uw.loop) begin
                            cnt_next = cnt_reg - 3'd1;
                            pc_next  = (cnt_reg != LOOP_LAST) ? uw.target : pc_reg + 2'd1;
                        end else begin
                            pc_next = pc_reg + 2'd1;
                        end
                    end
                    OP_MUL: begin
                        ctrl.mul = 1'b1;
                        pc_next  = pc_reg + 2'd1;
                    end
                    OP_DONE: begin
                        if (out_free) begin
                            ctrl.out_load = 1'b1;
                            m_valid_next  = 1'b1;
                        end
                    end
                    default: pc_next = UPC_START;
                endcase
            end
            default: pc_next = UPC_START;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= UPC_START;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/asbox_dp.sv]
// datapath: base and accumulator registers, shared gf(2^8) multiplier,
// affine transform and result registers; depends on asbox_pkg
module asbox_dp (
    input  logic                aclk,
    input  asbox_pkg::dp_ctrl_t ctrl,
    input  logic [7:0]          in_byte,
    output logic [7:0]          sbox_byte,
    output logic [7:0]          field_inverse
);
    import asbox_pkg::*;

    logic [7:0] base_reg;
    logic [7:0] acc_reg;
    logic [7:0] sbox_reg;
    logic [7:0] inv_reg;
    logic [7:0] prod;

    assign prod = gf_mul(ctrl.mul ? acc_reg : base_reg, base_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            base_reg <= in_byte;
            acc_reg  <= ONE_BYTE;
        end
        if (ctrl.sqr) begin
            base_reg <= prod;
        end
        if (ctrl.mul) begin
            acc_reg <= prod;
        end
        if (ctrl.out_load) begin
            inv_reg  <= acc_reg;
            sbox_reg <= affine(acc_reg);
        end
    end

    assign sbox_byte     = sbox_reg;
    assign field_inverse = inv_reg;

endmodule

[rtl/aes_sbox_from_inverse_unit.sv]
// AES s-box unit: one byte in, s-box value and gf(2^8) inverse out.
// The inverse is x^254, formed by a four-word microprogram that drives a
// single gf(2^8) multiplier; a beat runs its steps in order from acceptance to
// result (one square, seven multiply/square pairs, one final step), one at a
// time on the shared multiplier. A result waits in an output register, and a
// new beat may be accepted while it waits. Depends on asbox_pkg,
// asbox_useq, asbox_dp and assert_macros.svh.
`include "assert_macros.svh"
module aes_sbox_from_inverse_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_sbox_byte,
    output logic [7:0] m_field_inverse
);
    import asbox_pkg::*;

    dp_ctrl_t ctrl;

    asbox_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    asbox_dp u_dp (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .in_byte       (s_in_byte),
        .sbox_byte     (m_sbox_byte),
        .field_inverse (m_field_inverse)
    );

    // an accepted beat makes the unit busy
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a new result only appears at the end of a run
    `ASSERT_IMPL(a_result_after_run, aclk, aresetn, $rose(m_valid), $past(!s_ready))
    // zero inverse gives the affine constant
    `ASSERT_IMPL(a_zero_maps, aclk, aresetn, m_valid && (m_field_inverse == 8'h00), m_sbox_byte == AFFINE_CONST)
    // datapath is never told to square and multiply at once, nor to load while doing either
    `ASSERT_IMPL(a_one_op, aclk, aresetn, ctrl.sqr || ctrl.mul, !(ctrl.sqr && ctrl.mul) && !ctrl.load)

endmodule

[bench/tb_aes_sbox_from_inverse_unit.sv]
// self-checking bench for aes_sbox_from_inverse_unit: directed and random bytes
// with an independent gf(2^8) inverse and s-box predictor. needs only the rtl
// of the unit and its package.
`timescale 1ns / 100ps
module tb_aes_sbox_from_inverse_unit;

    localparam int   CLK_PERIOD   = 20;
    localparam int   RANDOM_BYTES = 650;
    localparam int   MAX_GAP      = 4;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   HOLD_AFTER   = 120;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   CYCLE_LIMIT  = 100000;
    localparam logic [8:0] FIELD_POLY = 9'h11B;
    localparam logic [7:0] SBOX_ADD   = 8'h63;

    typedef struct packed {
        logic [7:0] sbox;
        logic [7:0] inv;
    } sbox_pair_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        logic [7:0] sbox;
        logic [7:0] inv;
    } byte_row_t;

    localparam int DIR_ROWS = 20;

    // typed rows: zero has no inverse, one is its own inverse, top byte
    byte_row_t byte_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 8'h63, 8'h00},
        '{8'h01, 1'b1, 8'h7C, 8'h01},
        '{8'hFF, 1'b1, 8'h16, 8'h1C},
        '{8'h80, 1'b0, 8'h00, 8'h00},
        '{8'h7F, 1'b0, 8'h00, 8'h00},
        '{8'hFE, 1'b0, 8'h00, 8'h00},
        '{8'h02, 1'b0, 8'h00, 8'h00},
        '{8'h03, 1'b0, 8'h00, 8'h00},
        '{8'h04, 1'b0, 8'h00, 8'h00},
        '{8'h08, 1'b0, 8'h00, 8'h00},
        '{8'h10, 1'b0, 8'h00, 8'h00},
        '{8'h20, 1'b0, 8'h00, 8'h00},
        '{8'h40, 1'b0, 8'h00, 8'h00},
        '{8'h53, 1'b0, 8'h00, 8'h00},
        '{8'h55, 1'b0, 8'h00, 8'h00},
        '{8'hAA, 1'b0, 8'h00, 8'h00},
        '{8'h0F, 1'b0, 8'h00, 8'h00},
        '{8'hF0, 1'b0, 8'h00, 8'h00},
        '{8'h00, 1'b1, 8'h63, 8'h00},
        '{8'h01, 1'b1, 8'h7C, 8'h01}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_sbox_byte;
    logic [7:0] m_field_inverse;

    sbox_pair_t sbox_expect_q [$];
    int         fail_count;
    int         bytes_sent;
    int         results_checked;
    int         cycle_count;
    logic       hold_off;
    logic       no_idle;

    aes_sbox_from_inverse_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sbox_byte     (m_sbox_byte),
        .m_field_inverse (m_field_inverse)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // carry-less product, then reduction by the field polynomial
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] wide;
        wide = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                wide = wide ^ (15'(a) << i);
            end
        end
        for (int j = 14; j >= 8; j--) begin
            if (wide[j]) begin
                wide = wide ^ (15'(FIELD_POLY) << (j - 8));
            end
        end
        return wide[7:0];
    endfunction

    function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
        logic [7:0] found;
        found = '0;
        for (int c = 1; c < 256; c++) begin
            if (a != 8'h00 && gf_product(a, 8'(c)) == 8'h01) begin
                found = 8'(c);
            end
        end
        return found;
    endfunction

    // classic form: b ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63
    function automatic sbox_pair_t predict_substitution(input logic [7:0] a);
        sbox_pair_t r;
        logic [7:0] v;
        r.inv  = gf_reciprocal(a);
        v      = r.inv;
        r.sbox = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
               ^ {v[3:0], v[7:4]} ^ SBOX_ADD;
        return r;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input sbox_pair_t want);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        sbox_expect_q.push_back(want);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // long output stall once the stream is running, so the unit backs up
    initial begin
        hold_off = 1'b0;
        wait (bytes_sent >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        sbox_pair_t got;
        sbox_pair_t want;
        int         stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0 || hold_off) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                while (hold_off) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_valid && m_ready));
            got.sbox = m_sbox_byte;
            got.inv  = m_field_inverse;
            if (sbox_expect_q.size() == 0) begin
                $error("unexpected beat: sbox_byte %h field_inverse %h", got.sbox, got.inv);
                fail_count++;
            end else begin
                want = sbox_expect_q.pop_front();
                if (got.sbox !== want.sbox) begin
                    $error("sbox_byte expected %h actual %h", want.sbox, got.sbox);
                    fail_count++;
                end
                if (got.inv !== want.inv) begin
                    $error("field_inverse expected %h actual %h", want.inv, got.inv);
                    fail_count++;
                end
            end
            results_checked++;
            @(negedge aclk);
        end
    end

    initial begin
        sbox_pair_t want;
        logic [7:0] b;
        fail_count      = 0;
        bytes_sent      = 0;
        results_checked = 0;
        cycle_count     = 0;
        no_idle         = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_in_byte       = 8'h00;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            b = byte_rows[i].in_byte;
            if (byte_rows[i].typed) begin
                want.sbox = byte_rows[i].sbox;
                want.inv  = byte_rows[i].inv;
            end else begin
                want = predict_substitution(b);
            end
            send_byte(b, want);
            sender_gap();
        end

        for (int n = 0; n < RANDOM_BYTES; n++) begin
            // every third block of fifty runs back to back on both sides
            no_idle = ((n / 50) % 3 == 1);
            b = 8'($urandom_range(0, 255));
            send_byte(b, predict_substitution(b));
            sender_gap();
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (sbox_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d directed and %0d random bytes, %0d beats checked",
                 DIR_ROWS, RANDOM_BYTES, results_checked);
        $display("including a %0d-cycle output stall with input backpressure", HOLD_CYCLES);
        if (fail_count == 0 && sbox_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
